// ===== src/pwl_pkg.sv =====
// Package for the piecewise linear table interpolator.
// Holds the input and result word types and the status codes; no dependencies.
package pwl_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;

  typedef enum logic [1:0] {
    FuncClear = 2'd0,
    FuncLoad  = 2'd1,
    FuncEval  = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 3'd0,
    StRange = 3'd1,
    StEmpty = 3'd2,
    StDup   = 3'd3,
    StFull  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [DataW-1:0] arg_x;
    logic signed [DataW-1:0] point_y;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [StatusW-1:0]      status;
    logic [CountW-1:0]       point_count;
    logic signed [DataW-1:0] max_y;
    logic signed [DataW-1:0] min_y;
  } rsp_t;

endpackage

// ===== src/piecewise_linear_table_interpolator.sv =====
// Piecewise linear table interpolator: sorted breakpoint memory, serial scan
// and a bit-serial divider. Depends on pwl_pkg.
//
// A word is taken when start_i is high and busy_o is low. Its one result
// word appears on rsp_o for a single cycle with done_o high, in the same
// cycle in which busy_o falls, and cannot be held off. The memory read is
// registered, so the scan and the shift each pass through a wait state
// (SScanW, SShW) for every entry. A clear or an unused code never raises
// busy_o and answers in the next cycle. A load scans from the bottom to its
// place, shifts the entries above it up by one and writes the new point. An
// evaluate scans to the bracketing pair, reads both neighbors, forms the
// slope product in one multiply and runs a restoring divider, one quotient
// bit per cycle.
module piecewise_linear_table_interpolator import pwl_pkg::*; #(
  parameter int unsigned POINTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned NW = $clog2(POINTS + 1);
  localparam int unsigned PW = 2 * DataW + 1;

  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SScan  = 10'b0000000010,
    SScanW = 10'b0000000100,
    SShift = 10'b0000001000,
    SShW   = 10'b0000010000,
    SIns   = 10'b0000100000,
    SRd1   = 10'b0001000000,
    SRd2   = 10'b0010000000,
    SMul   = 10'b0100000000,
    SDiv   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [2*DataW-1:0] mem_q [POINTS];
  logic [2*DataW-1:0] rd_q;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [2*DataW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  logic [NW-1:0]           count_q, count_d;
  logic [NW-1:0]           idx_q, idx_d;
  logic [1:0]              func_q, func_d;
  logic signed [DataW-1:0] ax_q, ax_d, ay_q, ay_d;
  logic signed [DataW-1:0] maxy_q, maxy_d, miny_q, miny_d;
  logic signed [DataW-1:0] x0_q, x0_d, y0_q, y0_d;
  logic                    neg_q, neg_d;
  logic [2*DataW-1:0]      num_q, num_d;
  logic [DataW:0]          den_q, den_d;
  logic [DataW:0]          rem_q, rem_d;
  logic [6:0]              bit_q, bit_d;
  logic                    done_q, done_d;
  rsp_t                    rsp_q, rsp_d;

  logic signed [DataW-1:0] rx, ry;
  logic signed [DataW:0]   dyw, dxa, dx;
  logic [DataW:0]          mag;
  logic [DataW+1:0]        rtry;
  logic signed [PW-1:0]    sum;
  logic [2*DataW-1:0]      prod;

  assign rx = rd_q[2*DataW-1:DataW];
  assign ry = rd_q[DataW-1:0];
  assign dyw = {ry[DataW-1], ry} - {y0_q[DataW-1], y0_q};
  assign mag = dyw[DataW] ? (DataW + 1)'(0) - dyw : dyw;
  assign dxa = {ax_q[DataW-1], ax_q} - {x0_q[DataW-1], x0_q};
  assign dx  = {rx[DataW-1], rx} - {x0_q[DataW-1], x0_q};
  assign prod = 64'(mag) * 64'(dxa);
  assign rtry = {rem_q, num_q[2*DataW-1]} - {1'b0, den_q};

  function automatic rsp_t mk(logic signed [DataW-1:0] v, status_e s, logic [NW-1:0] c,
                              logic signed [DataW-1:0] mx, logic signed [DataW-1:0] mn);
    rsp_t r;
    r.value       = v;
    r.status      = s;
    r.point_count = CountW'(c);
    r.max_y       = mx;
    r.min_y       = mn;
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    func_d  = func_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    maxy_d  = maxy_q;
    miny_d  = miny_q;
    x0_d    = x0_q;
    y0_d    = y0_q;
    neg_d   = neg_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = AW'(idx_q);
    wdata   = {ax_q, ay_q};
    raddr   = AW'(idx_q);
    sum     = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          func_d = req_i.func;
          ax_d   = req_i.arg_x;
          ay_d   = req_i.point_y;
          idx_d  = '0;
          raddr  = '0;
          unique case (func_e'(req_i.func))
            FuncClear: begin
              count_d = '0;
              maxy_d  = '0;
              miny_d  = '0;
              done_d  = 1'b1;
              rsp_d   = mk('0, StOk, '0, '0, '0);
            end
            FuncLoad: begin
              if (count_q >= NW'(POINTS)) begin
                done_d = 1'b1;
                rsp_d  = mk('0, StFull, count_q, maxy_q, miny_q);
              end else if (count_q == '0) begin
                state_d = SIns;
              end else begin
                state_d = SScanW;
              end
            end
            FuncEval: begin
              if (count_q == '0) begin
                done_d = 1'b1;
                rsp_d  = mk('0, StEmpty, count_q, maxy_q, miny_q);
              end else begin
                state_d = SScanW;
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = mk('0, StOk, count_q, maxy_q, miny_q);
            end
          endcase
        end
      end
      SScanW: begin
        state_d = SScan;
      end
      SScan: begin
        if (func_q == FuncLoad) begin
          if (rx == ax_q) begin
            done_d  = 1'b1;
            rsp_d   = mk('0, StDup, count_q, maxy_q, miny_q);
            state_d = SIdle;
          end else if (rx > ax_q) begin
            bit_d   = 7'(0);
            x0_d    = DataW'(count_q);
            idx_d   = count_q - NW'(1);
            raddr   = AW'(count_q - NW'(1));
            rem_d   = (DataW + 1)'(idx_q);
            state_d = SShW;
          end else if (idx_q + NW'(1) >= count_q) begin
            idx_d   = count_q;
            state_d = SIns;
          end else begin
            idx_d   = idx_q + NW'(1);
            raddr   = AW'(idx_q + NW'(1));
            state_d = SScanW;
          end
        end else begin
          if (idx_q == '0 && ax_q < rx) begin
            done_d  = 1'b1;
            rsp_d   = mk('0, StRange, count_q, maxy_q, miny_q);
            state_d = SIdle;
          end else if (rx > ax_q) begin
            idx_d   = idx_q - NW'(1);
            raddr   = AW'(idx_q - NW'(1));
            state_d = SRd1;
          end else if (idx_q + NW'(1) >= count_q) begin
            done_d  = 1'b1;
            state_d = SIdle;
            if (rx == ax_q) rsp_d = mk(ry, StOk, count_q, maxy_q, miny_q);
            else            rsp_d = mk('0, StRange, count_q, maxy_q, miny_q);
          end else begin
            idx_d   = idx_q + NW'(1);
            raddr   = AW'(idx_q + NW'(1));
            state_d = SScanW;
          end
        end
      end
      SShW: begin
        state_d = SShift;
      end
      SShift: begin
        we    = 1'b1;
        waddr = AW'(idx_q + NW'(1));
        wdata = rd_q;
        if (idx_q == NW'(rem_q)) begin
          state_d = SIns;
        end else begin
          idx_d   = idx_q - NW'(1);
          raddr   = AW'(idx_q - NW'(1));
          state_d = SShW;
        end
      end
      SIns: begin
        we      = 1'b1;
        count_d = count_q + NW'(1);
        if (count_q == '0) begin
          maxy_d = ay_q;
          miny_d = ay_q;
        end else begin
          maxy_d = (ay_q > maxy_q) ? ay_q : maxy_q;
          miny_d = (ay_q < miny_q) ? ay_q : miny_q;
        end
        done_d  = 1'b1;
        rsp_d   = mk('0, StOk, count_q + NW'(1), maxy_d, miny_d);
        state_d = SIdle;
      end
      SRd1: begin
        x0_d    = rx;
        y0_d    = ry;
        raddr   = AW'(idx_q + NW'(1));
        state_d = SRd2;
      end
      SRd2: begin
        raddr   = AW'(idx_q + NW'(1));
        state_d = SMul;
      end
      SMul: begin
        neg_d   = dyw[DataW];
        num_d   = prod;
        den_d   = dx;
        rem_d   = '0;
        bit_d   = 7'(2 * DataW);
        state_d = SDiv;
      end
      SDiv: begin
        if (bit_q == '0) begin
          sum = neg_q ? PW'(y0_q) - PW'(num_q) : PW'(y0_q) + PW'(num_q);
          done_d = 1'b1;
          state_d = SIdle;
          if (sum > PW'(64'sh7fffffff))
            rsp_d = mk(32'sh7fffffff, StOk, count_q, maxy_q, miny_q);
          else if (sum < -PW'(64'sh80000000))
            rsp_d = mk(32'sh80000000, StOk, count_q, maxy_q, miny_q);
          else
            rsp_d = mk(sum[DataW-1:0], StOk, count_q, maxy_q, miny_q);
        end else begin
          bit_d = bit_q - 7'(1);
          if (!rtry[DataW+1]) begin
            rem_d = rtry[DataW:0];
            num_d = {num_q[2*DataW-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[DataW-1:0], num_q[2*DataW-1]};
            num_d = {num_q[2*DataW-2:0], 1'b0};
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      maxy_q  <= '0;
      miny_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      maxy_q  <= maxy_d;
      miny_q  <= miny_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    func_q <= func_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    neg_q  <= neg_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the piecewise linear table interpolator: directed and random
// clear/load/evaluate words checked against an in-bench table predictor.
// Depends on pwl_pkg and piecewise_linear_table_interpolator.
`timescale 1ns / 1ps

module testbench;
  import pwl_pkg::*;

  localparam int Points = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  piecewise_linear_table_interpolator #(.POINTS(Points)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic signed [31:0] tbl_x [Points];
  logic signed [31:0] tbl_y [Points];
  int tbl_n;
  logic signed [31:0] hi_y, lo_y;
  rsp_t expected_rsp [$];
  int errors;

  function automatic rsp_t predict_word(req_t w);
    rsp_t r;
    int pos, i;
    longint a, dy, dxa, dx, q, v;
    longint unsigned mag, uq;
    r = '0;
    r.status = StOk;
    case (func_e'(w.func))
      FuncClear: begin
        tbl_n = 0;
        hi_y = 0;
        lo_y = 0;
      end
      FuncLoad: begin
        pos = 0;
        if (tbl_n >= Points) begin
          r.status = StFull;
        end else begin
          while (pos < tbl_n && tbl_x[pos] < w.arg_x) pos++;
          if (pos < tbl_n && tbl_x[pos] == w.arg_x) begin
            r.status = StDup;
          end else begin
            for (i = tbl_n; i > pos; i--) begin
              tbl_x[i] = tbl_x[i-1];
              tbl_y[i] = tbl_y[i-1];
            end
            tbl_x[pos] = w.arg_x;
            tbl_y[pos] = w.point_y;
            if (tbl_n == 0) begin
              hi_y = w.point_y;
              lo_y = w.point_y;
            end else begin
              if (w.point_y > hi_y) hi_y = w.point_y;
              if (w.point_y < lo_y) lo_y = w.point_y;
            end
            tbl_n++;
          end
        end
      end
      FuncEval: begin
        a = w.arg_x;
        i = 0;
        if (tbl_n == 0) begin
          r.status = StEmpty;
        end else if (a < tbl_x[0] || a > tbl_x[tbl_n-1]) begin
          r.status = StRange;
        end else begin
          while (i + 1 < tbl_n && tbl_x[i+1] <= a) i++;
          if (i + 1 >= tbl_n) begin
            r.value = tbl_y[i];
          end else begin
            dy = longint'(tbl_y[i+1]) - longint'(tbl_y[i]);
            dxa = a - longint'(tbl_x[i]);
            dx = longint'(tbl_x[i+1]) - longint'(tbl_x[i]);
            mag = dy < 0 ? -dy : dy;
            uq = (mag * longint'(unsigned'(dxa))) / longint'(unsigned'(dx));
            q = longint'(uq);
            v = dy < 0 ? longint'(tbl_y[i]) - q : longint'(tbl_y[i]) + q;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.value = v[31:0];
          end
        end
      end
      default: ;
    endcase
    r.point_count = tbl_n[6:0];
    r.max_y = hi_y;
    r.min_y = lo_y;
    return r;
  endfunction

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp_o.value !== e.value) begin
          $error("value exp %0d got %0d", e.value, rsp_o.value); errors++;
        end
        if (rsp_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp_o.status); errors++;
        end
        if (rsp_o.point_count !== e.point_count) begin
          $error("point_count exp %0d got %0d", e.point_count, rsp_o.point_count);
          errors++;
        end
        if (rsp_o.max_y !== e.max_y) begin
          $error("max_y exp %0d got %0d", e.max_y, rsp_o.max_y); errors++;
        end
        if (rsp_o.min_y !== e.min_y) begin
          $error("min_y exp %0d got %0d", e.min_y, rsp_o.min_y); errors++;
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    req_t j;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      j.func = 2'($urandom);
      j.arg_x = $urandom;
      j.point_y = $urandom;
      start_i <= 1'b0;
      req_i <= j;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_word(func_e f, logic [31:0] x, logic [31:0] y);
    req_t w;
    w.func = f;
    w.arg_x = x;
    w.point_y = y;
    start_i <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy_o);
    expected_rsp.insert(expected_rsp.size(), predict_word(w));
    idle_gap();
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) << 16;
      3: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(FuncEval, 32'h0, 32'h0);
    send_word(FuncLoad, 32'h80000000, 32'h7fffffff);
    send_word(FuncLoad, 32'h7fffffff, 32'h80000000);
    send_word(FuncLoad, 32'h7fffffff, 32'h1);
    send_word(FuncEval, 32'h80000000, 32'h0);
    send_word(FuncEval, 32'h7fffffff, 32'h0);
    send_word(FuncEval, 32'h0, 32'hffffffff);
    send_word(FuncLoad, 32'h0, 32'h00010000);
    send_word(FuncEval, 32'hffffffff, 32'h0);
    send_word(FuncEval, 32'h00000001, 32'h0);
    send_word(FuncNone, 32'hffffffff, 32'hffffffff);
    send_word(FuncClear, 32'hffffffff, 32'hffffffff);
    send_word(FuncEval, 32'h0, 32'h0);
    send_word(FuncLoad, 32'h00010000, 32'h80000000);
    send_word(FuncLoad, 32'h00020000, 32'h7fffffff);
    send_word(FuncEval, 32'h00018000, 32'h0);
    send_word(FuncEval, 32'h0000ffff, 32'h0);
    send_word(FuncEval, 32'h00020001, 32'h0);
  endtask

  task automatic test_full_table();
    send_word(FuncClear, 32'h0, 32'h0);
    for (int i = 0; i < Points; i++)
      send_word(FuncLoad, (i * 37 % Points) << 12, $urandom);
    send_word(FuncLoad, 32'h00123456, 32'h0);
    send_word(FuncLoad, 32'h0, 32'h0);
    for (int i = 0; i < 20; i++)
      send_word(FuncEval, $urandom_range(0, (Points << 12) + 16) - 8, 32'h0);
  endtask

  task automatic test_random(int total);
    int sent;
    int tsize;
    sent = 0;
    while (sent < total) begin
      send_word(FuncClear, $urandom, $urandom);
      tsize = $urandom_range(0, 9) == 0 ? $urandom_range(20, 70) : $urandom_range(1, 8);
      for (int i = 0; i < tsize; i++) begin
        if ($urandom_range(0, 9) == 0 && tbl_n > 0)
          send_word(FuncLoad, tbl_x[$urandom_range(0, tbl_n - 1)], rand_val());
        else
          send_word(FuncLoad, rand_val(), rand_val());
      end
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_word(func_e'($urandom_range(0, 3) == 0 ? FuncNone : FuncEval),
                    rand_val(), $urandom);
        else if (tbl_n > 0 && $urandom_range(0, 3) == 0)
          send_word(FuncEval, tbl_x[$urandom_range(0, tbl_n - 1)], $urandom);
        else if (tbl_n > 1) begin
          int k;
          k = $urandom_range(0, tbl_n - 2);
          send_word(FuncEval, tbl_x[k] + ($urandom %
                    (longint'(tbl_x[k+1]) - longint'(tbl_x[k]))), $urandom);
        end else
          send_word(FuncEval, rand_val(), $urandom);
      end
      sent += tsize + 13;
    end
  endtask

  initial begin
    errors = 0;
    tbl_n = 0;
    hi_y = 0;
    lo_y = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random(1650);
    start_i <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12ns * 1500000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
src/pwl_pkg.sv
src/piecewise_linear_table_interpolator.sv
tb/sv/testbench.sv
